### sv/dsmq_pkg.sv
// ---------------------------------------------------------------------------
// Deadline-sorted message queue package
// Shared widths, operation codes and the packed records for stored entries
// and for result words.
// ---------------------------------------------------------------------------
package dsmq_pkg;

  // Default number of queue entries.
  localparam int DSMQ_DEPTH = 16;

  // Field widths.
  localparam int KIND_W  = 3;
  localparam int TIME_W  = 32;
  localparam int ID_W    = 16;
  localparam int PARAM_W = 16;
  localparam int CNT_W   = 5;

  // Operation codes carried by the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_POST         = 3'd0,
    KIND_COUNT        = 3'd1,
    KIND_CANCEL_FIRST = 3'd2,
    KIND_CANCEL_ALL   = 3'd3,
    KIND_POLL         = 3'd4
  } kind_t;

  // One stored message.
  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [ID_W-1:0]    id;
    logic [PARAM_W-1:0] param;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic               accepted;
    logic [CNT_W-1:0]   match_count;
    logic               has_message;
    logic [ID_W-1:0]    out_id;
    logic [PARAM_W-1:0] out_param;
    logic [TIME_W-1:0]  out_deadline;
    logic [CNT_W-1:0]   occupancy;
    logic               last;
  } res_t;

endpackage

### sv/dsmq_if.sv
// ---------------------------------------------------------------------------
// Deadline-sorted message queue channels
// Valid/ready channels for the request words and the result words.
// ---------------------------------------------------------------------------
interface dsmq_in_if;
  import dsmq_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [TIME_W-1:0]  now;
  logic [ID_W-1:0]    msg_id;
  logic [PARAM_W-1:0] msg_param;
  logic [TIME_W-1:0]  delay;

  modport source (output valid, kind, now, msg_id, msg_param, delay, input ready);
  modport sink   (input valid, kind, now, msg_id, msg_param, delay, output ready);
endinterface

interface dsmq_out_if;
  import dsmq_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted;
  logic [CNT_W-1:0]   match_count;
  logic               has_message;
  logic [ID_W-1:0]    out_id;
  logic [PARAM_W-1:0] out_param;
  logic [TIME_W-1:0]  out_deadline;
  logic [CNT_W-1:0]   occupancy;
  logic               last;

  modport source (output valid, accepted, match_count, has_message, out_id, out_param,
                  out_deadline, occupancy, last, input ready);
  modport sink   (input valid, accepted, match_count, has_message, out_id, out_param,
                  out_deadline, occupancy, last, output ready);
endinterface

### sv/dsmq_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module dsmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/deadline_sorted_message_queue_unit.sv
// ---------------------------------------------------------------------------
// Deadline-sorted message queue
// Holds up to DEPTH messages in a RAM kept sorted by deadline, walked by a
// small sequencer with one shared comparator.
// ---------------------------------------------------------------------------
// The queue takes one request word at a time and is not ready again until
// all of its result words have been produced. Every entry visit takes an
// S_RD state to issue the RAM read and an S_EV state to act on the
// registered data, since the single RAM read port is the bottleneck. A post
// walks from the tail, moving later entries up one place until it finds
// its slot; a count or a cancel walks every entry held; a poll first
// measures the due prefix, then hands out the due messages and compacts
// the rest towards the head. Output back-pressure can stall any of these.
// A full queue refuses a post without walking the entries. A result word
// may still wait in the output register while the next request is taken.
// There is no clearing pass after reset: only entries below the fill count
// are ever read.
module deadline_sorted_message_queue_unit #(
  parameter int DEPTH = dsmq_pkg::DSMQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dsmq_in_if.sink     in_ch,
  dsmq_out_if.source  out_ch
);
  import dsmq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_EMIT = 5'b01000,
    S_RES  = 5'b10000
  } state_t;

  // Keep the low bits of a count for a five-bit result field.
  function automatic logic [CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
    logic [CW+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, v};
    return w[CNT_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic [TIME_W-1:0]   key_r, key_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [PARAM_W-1:0]  param_r, param_nxt;
  logic                acc_r, acc_nxt;
  logic                poll2_r, poll2_nxt;
  logic [CW-1:0]       rd_r, rd_nxt;
  logic [CW-1:0]       wr_r, wr_nxt;
  logic [CW-1:0]       hit_r, hit_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                out_vld_r, out_vld_nxt;
  res_t                res_r, res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  entry_t              ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  entry_t              ram_rdata;

  logic                out_free;
  logic                key_lt;
  logic                id_eq;
  logic [CW-1:0]       rd_m1;
  logic [CW-1:0]       rd_p1;
  logic [CW-1:0]       rd_less_hit;
  entry_t              new_entry;

  // Entry store.
  dsmq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared comparator: post key against a stored deadline for the insert
  // point, or the current time against a stored deadline for due entries.
  assign key_lt      = key_r < ram_rdata.deadline;
  assign id_eq       = ram_rdata.id == id_r;
  assign rd_m1       = rd_r - CW'(1);
  assign rd_p1       = rd_r + CW'(1);
  assign rd_less_hit = rd_r - hit_r;
  assign new_entry   = '{deadline: key_r, id: id_r, param: param_r};
  assign out_free    = !out_vld_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    key_nxt     = key_r;
    id_nxt      = id_r;
    param_nxt   = param_r;
    acc_nxt     = acc_r;
    poll2_nxt   = poll2_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    hit_nxt     = hit_r;
    cnt_nxt     = cnt_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_r)
      // Take a request and set up the walk.
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt  = kind_t'(in_ch.kind);
          id_nxt    = in_ch.msg_id;
          param_nxt = in_ch.msg_param;
          key_nxt   = in_ch.now;
          acc_nxt   = 1'b0;
          poll2_nxt = 1'b0;
          hit_nxt   = '0;
          rd_nxt    = '0;
          wr_nxt    = '0;
          case (kind_t'(in_ch.kind))
            KIND_POST: begin
              key_nxt = in_ch.now + in_ch.delay;
              rd_nxt  = cnt_r;
              if (cnt_r == CW'(DEPTH)) begin
                state_nxt = S_RES;
              end else begin
                state_nxt = S_RD;
              end
            end
            KIND_COUNT, KIND_CANCEL_FIRST, KIND_CANCEL_ALL, KIND_POLL: begin
              state_nxt = S_RD;
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end
      end

      // Issue the next read, or finish the walk.
      S_RD: begin
        if (kind_r == KIND_POST) begin
          if (rd_r == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = new_entry;
            cnt_nxt   = cnt_r + CW'(1);
            acc_nxt   = 1'b1;
            state_nxt = S_RES;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = rd_m1[AW-1:0];
            state_nxt = S_EV;
          end
        end else if (rd_r == cnt_r) begin
          case (kind_r)
            KIND_CANCEL_FIRST, KIND_CANCEL_ALL: begin
              cnt_nxt   = wr_r;
              state_nxt = S_RES;
            end
            KIND_POLL: begin
              if (poll2_r) begin
                cnt_nxt   = cnt_r - hit_r;
                state_nxt = S_IDLE;
              end else if (hit_r == '0) begin
                state_nxt = S_RES;
              end else begin
                poll2_nxt = 1'b1;
                rd_nxt    = '0;
              end
            end
            default: begin
              state_nxt = S_RES;
            end
          endcase
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_r[AW-1:0];
          state_nxt = S_EV;
        end
      end

      // Act on the entry just read.
      S_EV: begin
        state_nxt = S_RD;
        case (kind_r)
          KIND_POST: begin
            // Move later deadlines up one place; stop behind an equal one.
            ram_we    = 1'b1;
            ram_waddr = rd_r[AW-1:0];
            if (key_lt) begin
              rd_nxt = rd_m1;
            end else begin
              ram_wdata = new_entry;
              cnt_nxt   = cnt_r + CW'(1);
              acc_nxt   = 1'b1;
              state_nxt = S_RES;
            end
          end
          KIND_COUNT: begin
            if (id_eq) begin
              hit_nxt = hit_r + CW'(1);
            end
            rd_nxt = rd_p1;
          end
          KIND_CANCEL_FIRST, KIND_CANCEL_ALL: begin
            // Drop the first match (every match for a cancel-all) and compact the survivors towards the head.
            if (id_eq && !(kind_r == KIND_CANCEL_FIRST && hit_r != '0)) begin
              hit_nxt = hit_r + CW'(1);
            end else begin
              ram_we    = 1'b1;
              ram_waddr = wr_r[AW-1:0];
              wr_nxt    = wr_r + CW'(1);
            end
            rd_nxt = rd_p1;
          end
          KIND_POLL: begin
            if (!poll2_r) begin
              // Measure the due prefix of the sorted queue.
              if (!key_lt) begin
                hit_nxt = hit_r + CW'(1);
                rd_nxt  = rd_p1;
              end else if (hit_r == '0) begin
                state_nxt = S_RES;
              end else begin
                poll2_nxt = 1'b1;
                rd_nxt    = '0;
              end
            end else if (rd_r < hit_r) begin
              state_nxt = S_EMIT;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = rd_less_hit[AW-1:0];
              rd_nxt    = rd_p1;
            end
          end
          default: begin
            state_nxt = S_RES;
          end
        endcase
      end

      // Hand out one due message; the read data holds meanwhile.
      S_EMIT: begin
        if (out_free) begin
          out_vld_nxt          = 1'b1;
          res_nxt              = '0;
          res_nxt.has_message  = 1'b1;
          res_nxt.out_id       = ram_rdata.id;
          res_nxt.out_param    = ram_rdata.param;
          res_nxt.out_deadline = ram_rdata.deadline;
          res_nxt.occupancy    = to_cnt(cnt_r - hit_r);
          res_nxt.last         = (rd_p1 == hit_r);
          rd_nxt               = rd_p1;
          state_nxt            = S_RD;
        end
      end

      // Single closing result word.
      S_RES: begin
        if (out_free) begin
          out_vld_nxt       = 1'b1;
          res_nxt           = '0;
          res_nxt.accepted  = acc_r;
          res_nxt.occupancy = to_cnt(cnt_r);
          res_nxt.last      = 1'b1;
          if (kind_r == KIND_COUNT || kind_r == KIND_CANCEL_FIRST ||
              kind_r == KIND_CANCEL_ALL) begin
            res_nxt.match_count = to_cnt(hit_r);
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
      poll2_r   <= 1'b0;
      rd_r      <= '0;
      wr_r      <= '0;
      hit_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      out_vld_r <= out_vld_nxt;
      poll2_r   <= poll2_nxt;
      rd_r      <= rd_nxt;
      wr_r      <= wr_nxt;
      hit_r     <= hit_nxt;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    key_r   <= key_nxt;
    id_r    <= id_nxt;
    param_r <= param_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
  end

  // Result channel.
  assign out_ch.valid        = out_vld_r;
  assign out_ch.accepted     = res_r.accepted;
  assign out_ch.match_count  = res_r.match_count;
  assign out_ch.has_message  = res_r.has_message;
  assign out_ch.out_id       = res_r.out_id;
  assign out_ch.out_param    = res_r.out_param;
  assign out_ch.out_deadline = res_r.out_deadline;
  assign out_ch.occupancy    = res_r.occupancy;
  assign out_ch.last         = res_r.last;

  // The fill count never exceeds the queue depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill count above depth");

  // During a walk, matches or due entries never outnumber the entries held.
  a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_EV || state_r == S_EMIT) |-> hit_r <= cnt_r)
    else $error("hit count above fill count");

  // Compaction never writes ahead of the read pointer.
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= rd_r)
    else $error("compaction write pointer overtook read pointer");

  // Messages are only handed out in the second phase of a poll.
  a_emit_poll: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> kind_r == KIND_POLL && poll2_r)
    else $error("message emitted outside a poll");

  // Writes stay inside the store.
  a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> int'(ram_waddr) < DEPTH)
    else $error("entry write beyond depth");

endmodule

### test/testbench.sv
// ---------------------------------------------------------------------------
// Deadline-sorted message queue testbench
// Drives request words through the valid/ready input channel with random
// gaps, predicts every result word from a behavioural copy of the queue and
// checks each result word field by field as it leaves the block. A short
// directed sequence covers the corner cases, then random episodes of posts,
// counts, cancels and polls over an advancing tick counter follow, mixed
// with fully random words.
// ---------------------------------------------------------------------------
module testbench;
  import dsmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 8;
  localparam int TARGET_REQUESTS = 470;
  localparam int DRAIN_CYCLES    = 100;

  // Kind codes that the block does not define.
  localparam logic [KIND_W-1:0] KIND_UNDEF_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNDEF_HI = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  now;
    logic [ID_W-1:0]    msg_id;
    logic [PARAM_W-1:0] msg_param;
    logic [TIME_W-1:0]  delay;
  } request_t;

  logic clk;
  logic rst_n;

  dsmq_in_if  in_ch ();
  dsmq_out_if out_ch ();

  deadline_sorted_message_queue_unit #(
    .DEPTH (DSMQ_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Request words waiting to be driven, and result words still owed.
  request_t pending_requests[$];
  res_t     expected_results[$];

  // Behavioural copy of the queue contents.
  entry_t held_entries[DSMQ_DEPTH];
  int     held_count;

  int  requests_queued;
  int  requests_taken;
  int  words_checked;
  int  messages_popped;
  int  posts_refused;
  int  mismatch_count;
  logic in_taken;
  logic calm_phase;

  // Clock.
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Gap length for either side: none during calm phases, otherwise mostly
  // short with the occasional long one.
  function automatic int unsigned draw_gap();
    int unsigned pick;
    if (calm_phase) begin
      return 0;
    end
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      return 0;
    end
    if (pick < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_request(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
                               input logic [ID_W-1:0] msg_id,
                               input logic [PARAM_W-1:0] msg_param,
                               input logic [TIME_W-1:0] delay);
    request_t rq;
    rq.kind      = kind;
    rq.now       = now;
    rq.msg_id    = msg_id;
    rq.msg_param = msg_param;
    rq.delay     = delay;
    pending_requests.push_back(rq);
    requests_queued++;
  endtask

  // Remove one held entry and close the hole behind it.
  function automatic void drop_entry(input int pos);
    int k;
    for (k = pos; k + 1 < held_count; k++) begin
      held_entries[k] = held_entries[k + 1];
    end
    held_count--;
  endfunction

  // Work out the result words of one accepted request and update the queue.
  function automatic void predict_queue_results(input request_t rq);
    res_t              r;
    res_t              popped[$];
    logic [TIME_W-1:0] dl;
    int                pos;
    int                match_total;
    int                i;
    r = '0;
    match_total = 0;
    if (rq.kind == KIND_POLL) begin
      // Pop the due prefix in queue order, one word per message.
      while (held_count > 0 && popped.size() < DSMQ_DEPTH &&
             held_entries[0].deadline <= rq.now) begin
        r = '0;
        r.has_message  = 1'b1;
        r.out_id       = held_entries[0].id;
        r.out_param    = held_entries[0].param;
        r.out_deadline = held_entries[0].deadline;
        popped.push_back(r);
        drop_entry(0);
      end
      if (popped.size() == 0) begin
        r = '0;
        popped.push_back(r);
      end
      foreach (popped[j]) begin
        popped[j].occupancy = CNT_W'(held_count);
        popped[j].last      = (j == popped.size() - 1);
        expected_results.push_back(popped[j]);
      end
      return;
    end
    case (rq.kind)
      KIND_POST: begin
        if (held_count < DSMQ_DEPTH) begin
          // A new message goes behind every entry due at or before it.
          dl  = rq.now + rq.delay;
          pos = 0;
          while (pos < held_count && held_entries[pos].deadline <= dl) begin
            pos++;
          end
          for (i = held_count; i > pos; i--) begin
            held_entries[i] = held_entries[i - 1];
          end
          held_entries[pos].deadline = dl;
          held_entries[pos].id       = rq.msg_id;
          held_entries[pos].param    = rq.msg_param;
          held_count++;
          r.accepted = 1'b1;
        end else begin
          posts_refused++;
        end
      end
      KIND_COUNT: begin
        for (i = 0; i < held_count; i++) begin
          if (held_entries[i].id == rq.msg_id) begin
            match_total++;
          end
        end
        r.match_count = CNT_W'(match_total);
      end
      KIND_CANCEL_FIRST: begin
        for (i = 0; i < held_count; i++) begin
          if (held_entries[i].id == rq.msg_id) begin
            drop_entry(i);
            match_total = 1;
            break;
          end
        end
        r.match_count = CNT_W'(match_total);
      end
      KIND_CANCEL_ALL: begin
        i = 0;
        while (i < held_count) begin
          if (held_entries[i].id == rq.msg_id) begin
            drop_entry(i);
            match_total++;
          end else begin
            i++;
          end
        end
        r.match_count = CNT_W'(match_total);
      end
      default: begin
        // Undefined kinds leave the queue alone.
      end
    endcase
    r.occupancy = CNT_W'(held_count);
    r.last      = 1'b1;
    expected_results.push_back(r);
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input logic [TIME_W-1:0] got);
    if (got !== want[TIME_W-1:0]) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Request driver: a new word is presented at the falling edge once the
  // previous one has been taken and its gap has run out.
  always @(negedge clk) begin : drive_requests
    int unsigned gap_left;
    request_t    rq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else if (in_ch.valid && !in_taken) begin
      // Hold the word until the block takes it.
    end else if (gap_left > 0) begin
      in_ch.valid <= 1'b0;
      gap_left--;
    end else if (pending_requests.size() > 0) begin
      rq = pending_requests.pop_front();
      in_ch.kind      <= rq.kind;
      in_ch.now       <= rq.now;
      in_ch.msg_id    <= rq.msg_id;
      in_ch.msg_param <= rq.msg_param;
      in_ch.delay     <= rq.delay;
      in_ch.valid     <= 1'b1;
      gap_left = draw_gap();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result receiver: random stalls on ready, with calm phases between.
  always @(negedge clk) begin : drive_ready
    int unsigned stall_left;
    int unsigned phase_left;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      phase_left = 0;
    end else begin
      if (phase_left == 0) begin
        calm_phase <= ~calm_phase;
        phase_left = $urandom_range(50, 300);
      end else begin
        phase_left--;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          stall_left = draw_gap();
        end
      end
    end
  end

  // Monitor: predict on every accepted request word, then check every
  // accepted result word against the oldest expectation.
  always @(posedge clk) begin : watch_channels
    request_t rq;
    res_t     want;
    if (rst_n) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        rq.kind      = in_ch.kind;
        rq.now       = in_ch.now;
        rq.msg_id    = in_ch.msg_id;
        rq.msg_param = in_ch.msg_param;
        rq.delay     = in_ch.delay;
        predict_queue_results(rq);
        requests_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result word with nothing expected, expected none, got id 0x%0h",
                   $time, out_ch.out_id);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, out_ch.accepted);
          check_field("match_count", want.match_count, out_ch.match_count);
          check_field("has_message", want.has_message, out_ch.has_message);
          check_field("out_id", want.out_id, out_ch.out_id);
          check_field("out_param", want.out_param, out_ch.out_param);
          check_field("out_deadline", want.out_deadline, out_ch.out_deadline);
          check_field("occupancy", want.occupancy, out_ch.occupancy);
          check_field("last", want.last, out_ch.last);
          words_checked++;
          if (out_ch.has_message === 1'b1) begin
            messages_popped++;
          end
        end
      end
    end else begin
      in_taken <= 1'b0;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_sequence
    logic [TIME_W-1:0] tick;
    logic [TIME_W-1:0] dly;
    int                n_posts;
    int                k;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = '0;
    in_ch.now       = '0;
    in_ch.msg_id    = '0;
    in_ch.msg_param = '0;
    in_ch.delay     = '0;
    out_ch.ready    = 1'b0;
    in_taken        = 1'b0;
    calm_phase      = 1'b0;
    held_count      = 0;
    requests_queued = 0;
    requests_taken  = 0;
    words_checked   = 0;
    messages_popped = 0;
    posts_refused   = 0;
    mismatch_count  = 0;

    // Directed part: empty queue, undefined kinds, wrap-around, tied and
    // extreme deadlines, cancel with and without a match, a full queue and a
    // poll that pops everything.
    queue_request(KIND_POLL, '0, '0, '0, '0);
    queue_request(KIND_CANCEL_FIRST, '1, '1, '1, '1);
    queue_request(KIND_UNDEF_LO, 32'd77, 16'h1234, 16'h5678, 32'd9);
    queue_request(KIND_POST, '0, '0, '0, '0);
    queue_request(KIND_POST, '1, '1, '1, 32'd1);
    queue_request(KIND_POST, '0, 16'd5, 16'hA5A5, '1);
    queue_request(KIND_POST, 32'd100, 16'd5, 16'h5A5A, '1);
    queue_request(KIND_COUNT, '0, 16'd5, '0, '0);
    queue_request(KIND_CANCEL_ALL, '0, 16'd3, '0, '0);
    queue_request(KIND_CANCEL_FIRST, '0, 16'd5, '0, '0);
    queue_request(KIND_UNDEF_HI, '1, '1, '1, '1);
    for (k = 0; k < 13; k++) begin
      queue_request(KIND_POST, 32'(k * 1000), 16'd9, 16'(k), $urandom_range(0, 5000));
    end
    queue_request(KIND_POST, 32'd42, 16'd11, 16'd11, 32'd1);
    queue_request(KIND_POLL, '1, '0, '0, '0);

    // Random part: episodes of posts with short delays over an advancing
    // tick, with counts and cancels on a small id pool, then polls; and
    // bursts of fully random words in between.
    tick = $urandom();
    while (requests_queued < TARGET_REQUESTS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          queue_request(KIND_W'($urandom_range(0, 7)), $urandom(), 16'($urandom()),
                        16'($urandom()), $urandom());
        end
      end else begin
        n_posts = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 8);
        for (k = 0; k < n_posts; k++) begin
          tick = tick + $urandom_range(0, 20);
          dly  = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 150);
          queue_request(KIND_POST, tick, 16'($urandom_range(1, 6)), 16'($urandom()), dly);
          if ($urandom_range(0, 4) == 0) begin
            queue_request(KIND_W'($urandom_range(KIND_COUNT, KIND_CANCEL_ALL)), tick,
                          16'($urandom_range(1, 7)), 16'($urandom()), $urandom());
          end
        end
        repeat ($urandom_range(1, 4)) begin
          tick = tick + $urandom_range(0, 120);
          queue_request(KIND_POLL, tick, 16'($urandom()), 16'($urandom()), $urandom());
        end
        // Now and then flush whatever is left, far-future entries included.
        if ($urandom_range(0, 4) == 0) begin
          queue_request(KIND_POLL, '1, 16'($urandom()), 16'($urandom()), $urandom());
        end
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every request word to be taken and every result to arrive.
    while (requests_taken < requests_queued || expected_results.size() > 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d request words, %0d posts refused on a full queue.",
             requests_taken, posts_refused);
    $display("Checked %0d result words, %0d of them popped messages.",
             words_checked, messages_popped);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #20ms;
    $display("%0t ns: run did not finish in time", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
sv/dsmq_pkg.sv
sv/dsmq_if.sv
sv/dsmq_ram.sv
sv/deadline_sorted_message_queue_unit.sv
test/testbench.sv
